[rtl/ptq_pkg.sv]
`default_nettype none

package ptq_pkg;

  localparam int unsigned TAG_W     = 8;
  localparam int unsigned TAG_COUNT = 256;
  localparam int unsigned LVL_COUNT = 4;
  localparam int unsigned LVL_W     = 2;
  localparam int unsigned PTR_W     = 9;
  localparam int unsigned TICKET_W  = 16;
  localparam int unsigned FIFO_AW   = LVL_W + TAG_W;

  localparam int unsigned S_DATA_W  = 32;
  localparam int unsigned M_DATA_W  = 48;
  localparam int unsigned RES_W     = 43;

  // request codes
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_CALL   = 3'd1;
  localparam logic [2:0] REQ_LOOKUP = 3'd2;
  localparam logic [2:0] REQ_CHANGE = 3'd3;
  localparam logic [2:0] REQ_CANCEL = 3'd4;

  // result codes
  localparam logic [2:0] RC_OK        = 3'd0;
  localparam logic [2:0] RC_BAD_PRIO  = 3'd1;
  localparam logic [2:0] RC_EXISTS    = 3'd2;
  localparam logic [2:0] RC_NOT_FOUND = 3'd3;
  localparam logic [2:0] RC_REFUSED   = 3'd4;
  localparam logic [2:0] RC_EMPTY     = 3'd5;
  localparam logic [2:0] RC_BAD_STATE = 3'd6;

  // entry states
  localparam logic [1:0] ST_WAITING   = 2'd0;
  localparam logic [1:0] ST_CALLED    = 2'd1;
  localparam logic [1:0] ST_DONE      = 2'd2;
  localparam logic [1:0] ST_CANCELLED = 2'd3;

  localparam logic [2:0] PRIO_MIN  = 3'd1;
  localparam logic [2:0] PRIO_MAX  = 3'd4;
  localparam logic [2:0] TGT_MAX   = 3'd3;
  localparam logic [PTR_W-1:0] FIFO_DEPTH = PTR_W'(TAG_COUNT);

  typedef struct packed {
    logic [10:0]         arrival;
    logic [1:0]          st;
    logic [TICKET_W-1:0] ticket;
    logic [2:0]          prio;
  } rec_t;

  typedef struct packed {
    logic [10:0]         out_arrival;
    logic [1:0]          out_state;
    logic [TICKET_W-1:0] out_ticket;
    logic [2:0]          out_priority;
    logic [TAG_W-1:0]    out_tag;
    logic [2:0]          result_code;
  } res_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EXEC  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FIFO  = 6'b001000,
    S_CHECK = 6'b010000,
    S_OUT   = 6'b100000
  } fsm_e;

  function automatic res_t res_none(input logic [2:0] code);
    res_t r;
    r             = '0;
    r.result_code = code;
    return r;
  endfunction

  function automatic res_t res_entry(input logic [2:0] code, input logic [TAG_W-1:0] tag,
                                     input rec_t rec);
    res_t r;
    r.result_code  = code;
    r.out_tag      = tag;
    r.out_priority = rec.prio;
    r.out_ticket   = rec.ticket;
    r.out_state    = rec.st;
    r.out_arrival  = rec.arrival;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/priority_ticket_queue_unit.sv]
`default_nettype none

// Four-level priority ticket queue, FIFO order inside a level. Records for the 256 tags sit in a
// synchronous record memory with one valid flop per tag (cleared at reset, so no clearing pass
// is needed); each level has a ring of tags in a second memory. Insert, look up, change state
// and cancel each step through accept (record read), record read-modify-write and output load.
// Call next steps through accept, a head pop / ring read, record read and state check for each
// queued slot it examines, a last scan when no waiting entry turns up, and output load, since
// stale slots that are no longer waiting are dropped one by one.
// A new request is taken while the previous result still waits in the output register.
module priority_ticket_queue_unit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // req_type[2:0], entry_tag[10:3], priority_level[13:11], arrival_minute[24:14],
  // target_state[27:25], zero fill above
  input  wire logic [ptq_pkg::S_DATA_W-1:0]  s_axis_tdata,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // result_code[2:0], out_tag[10:3], out_priority[13:11], out_ticket[29:14],
  // out_state[31:30], out_arrival[42:32], zero fill above
  output logic [ptq_pkg::M_DATA_W-1:0]       m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready
);
  import ptq_pkg::*;

  fsm_e state_q, state_d;

  logic [2:0]       req_q, prio_q, tgt_q;
  logic [TAG_W-1:0] tag_q;
  logic [10:0]      arr_q;

  logic [TAG_COUNT-1:0]                valid_q;
  logic [LVL_COUNT-1:0][PTR_W-1:0]     heads_q, tails_q;
  logic [TICKET_W-1:0]                 ticket_q;

  rec_t             rec_mem [TAG_COUNT];
  logic [TAG_W-1:0] fifo_mem [2**FIFO_AW];

  rec_t             rec_rd_q;
  logic [TAG_W-1:0] fifo_rd_q;
  logic [TAG_W-1:0] rec_raddr;
  logic [FIFO_AW-1:0] fifo_raddr, fifo_waddr;

  logic             rec_we, fifo_we, head_pop, res_en, s_beat;
  rec_t             rec_wdata;
  logic [TAG_W-1:0] rec_waddr;
  logic [LVL_W-1:0] ins_lv, scan_lv;
  logic             any_ready, fifo_ok;
  res_t             res_q, res_d;
  logic             m_valid_q;
  logic [M_DATA_W-1:0] m_data_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign rec_raddr  = (state_q == S_IDLE) ? s_axis_tdata[10:3] : fifo_rd_q;
  assign ins_lv     = LVL_W'(prio_q - PRIO_MIN);
  assign fifo_waddr = {ins_lv, tails_q[ins_lv][TAG_W-1:0]};
  assign fifo_raddr = {scan_lv, heads_q[scan_lv][TAG_W-1:0]};

  // most urgent level that still holds slots
  always_comb begin
    scan_lv   = '0;
    any_ready = 1'b0;
    for (int l = LVL_COUNT - 1; l >= 0; l--) begin
      if (heads_q[l] != tails_q[l]) begin
        scan_lv   = LVL_W'(l);
        any_ready = 1'b1;
      end
    end
  end

  always_comb begin
    rec_t cur;
    rec_t upd;
    logic vld;
    cur       = rec_rd_q;
    upd       = rec_rd_q;
    vld       = valid_q[tag_q];
    state_d   = state_q;
    rec_we    = 1'b0;
    rec_wdata = rec_rd_q;
    rec_waddr = tag_q;
    fifo_we   = 1'b0;
    head_pop  = 1'b0;
    res_en    = 1'b0;
    res_d     = res_none(RC_REFUSED);
    unique case (state_q)
      S_IDLE: begin
        if (s_beat) begin
          state_d = (s_axis_tdata[2:0] == REQ_CALL) ? S_SCAN : S_EXEC;
        end
      end
      S_EXEC: begin
        res_en  = 1'b1;
        state_d = S_OUT;
        case (req_q)
          REQ_INSERT: begin
            if (prio_q < PRIO_MIN || prio_q > PRIO_MAX) begin
              res_d = res_none(RC_BAD_PRIO);
            end else if (vld) begin
              res_d = res_entry(RC_EXISTS, tag_q, cur);
            end else begin
              upd.arrival = arr_q;
              upd.st      = ST_WAITING;
              upd.ticket  = ticket_q;
              upd.prio    = prio_q;
              rec_we      = 1'b1;
              rec_wdata   = upd;
              fifo_we     = 1'b1;
              res_d       = res_entry(RC_OK, tag_q, upd);
            end
          end
          REQ_LOOKUP: begin
            res_d = vld ? res_entry(RC_OK, tag_q, cur) : res_none(RC_NOT_FOUND);
          end
          REQ_CHANGE: begin
            if (tgt_q > TGT_MAX) begin
              res_d = res_none(RC_BAD_STATE);
            end else if (!vld) begin
              res_d = res_none(RC_NOT_FOUND);
            end else if ((cur.st == ST_WAITING && tgt_q[1:0] == ST_CALLED) ||
                         (cur.st == ST_CALLED  && tgt_q[1:0] == ST_DONE) ||
                         (cur.st == ST_WAITING && tgt_q[1:0] == ST_CANCELLED)) begin
              upd.st    = tgt_q[1:0];
              rec_we    = 1'b1;
              rec_wdata = upd;
              res_d     = res_entry(RC_OK, tag_q, upd);
            end else begin
              res_d = res_entry(RC_REFUSED, tag_q, cur);
            end
          end
          REQ_CANCEL: begin
            if (!vld) begin
              res_d = res_none(RC_NOT_FOUND);
            end else if (cur.st != ST_WAITING) begin
              res_d = res_entry(RC_REFUSED, tag_q, cur);
            end else begin
              upd.st    = ST_CANCELLED;
              rec_we    = 1'b1;
              rec_wdata = upd;
              res_d     = res_entry(RC_OK, tag_q, upd);
            end
          end
          default: res_d = res_none(RC_REFUSED);
        endcase
      end
      S_SCAN: begin
        if (any_ready) begin
          head_pop = 1'b1;
          state_d  = S_FIFO;
        end else begin
          res_en  = 1'b1;
          res_d   = res_none(RC_EMPTY);
          state_d = S_OUT;
        end
      end
      S_FIFO: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        // a waiting entry is called; a stale slot is dropped and the scan looks again
        if (vld && cur.st == ST_WAITING) begin
          upd.st    = ST_CALLED;
          rec_we    = 1'b1;
          rec_wdata = upd;
          res_en    = 1'b1;
          res_d     = res_entry(RC_OK, tag_q, upd);
          state_d   = S_OUT;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_waddr] <= rec_wdata;
    end
    rec_rd_q <= rec_mem[rec_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[fifo_waddr] <= tag_q;
    end
    fifo_rd_q <= fifo_mem[fifo_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s_beat) begin
      req_q  <= s_axis_tdata[2:0];
      tag_q  <= s_axis_tdata[10:3];
      prio_q <= s_axis_tdata[13:11];
      arr_q  <= s_axis_tdata[24:14];
      tgt_q  <= s_axis_tdata[27:25];
    end else if (state_q == S_FIFO) begin
      tag_q <= fifo_rd_q;
    end
    if (res_en) begin
      res_q <= res_d;
    end
    if (state_q == S_OUT && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {(M_DATA_W - RES_W)'(0), res_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      valid_q   <= '0;
      heads_q   <= '0;
      tails_q   <= '0;
      ticket_q  <= TICKET_W'(1);
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fifo_we) begin
        valid_q[tag_q]  <= 1'b1;
        tails_q[ins_lv] <= tails_q[ins_lv] + PTR_W'(1);
        ticket_q        <= ticket_q + TICKET_W'(1);
      end
      if (head_pop) begin
        heads_q[scan_lv] <= heads_q[scan_lv] + PTR_W'(1);
      end
      if (state_q == S_OUT && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // no ring ever holds more slots than there are tags
  always_comb begin
    fifo_ok = 1'b1;
    for (int l = 0; l < LVL_COUNT; l++) begin
      if (PTR_W'(tails_q[l] - heads_q[l]) > FIFO_DEPTH) begin
        fifo_ok = 1'b0;
      end
    end
  end

  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) fifo_ok)
    else $error("level ring over capacity");

  a_ticket_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ticket_q != $past(ticket_q)) |-> $past(fifo_we))
    else $error("ticket advanced without an insert");

  a_insert_marks_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_we |=> valid_q[$past(tag_q)])
    else $error("inserted tag not marked valid");

  a_out_from_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !$past(m_valid_q)) |-> $past(state_q == S_OUT))
    else $error("result beat raised outside output state");

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;
  import ptq_pkg::*;

  // request codes the block does not know
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  localparam int unsigned PHASE_ITEMS = 160;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  tag;
    logic [2:0]  prio;
    logic [10:0] arrival;
    logic [2:0]  target;
  } request_t;

  typedef struct {
    logic        used;
    logic [2:0]  prio;
    logic [15:0] ticket;
    logic [1:0]  st;
    logic [10:0] arrival;
  } ticket_rec_t;

  typedef struct {
    request_t rq;
    bit       typed;
    res_t     want;
  } plan_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;

  // predicted queue contents
  ticket_rec_t      tickets [TAG_COUNT];
  logic [TAG_W-1:0] level_ring [LVL_COUNT][TAG_COUNT];
  logic [PTR_W-1:0] ring_head [LVL_COUNT];
  logic [PTR_W-1:0] ring_tail [LVL_COUNT];
  logic [15:0]      ticket_counter;
  logic [TAG_W-1:0] used_tags[$];

  res_t        pending_results[$];
  plan_row_t   directed_plan[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned rx_hold = 0;

  priority_ticket_queue_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic res_t entry_report(input logic [2:0] code, input logic [TAG_W-1:0] tag);
    res_t r;
    r.result_code  = code;
    r.out_tag      = tag;
    r.out_priority = tickets[tag].prio;
    r.out_ticket   = tickets[tag].ticket;
    r.out_state    = tickets[tag].st;
    r.out_arrival  = tickets[tag].arrival;
    return r;
  endfunction

  // every tag fits the record store, so the model needs no out-of-range tag check
  function automatic res_t queue_model_step(input request_t rq);
    res_t             r;
    logic [1:0]       lv;
    logic [TAG_W-1:0] t;
    logic             found;
    logic             allowed;
    r = '0;
    case (rq.req)
      REQ_INSERT: begin
        if (rq.prio < PRIO_MIN || rq.prio > PRIO_MAX) begin
          r.result_code = RC_BAD_PRIO;
        end else if (tickets[rq.tag].used) begin
          r = entry_report(RC_EXISTS, rq.tag);
        end else begin
          tickets[rq.tag] = '{used: 1'b1, prio: rq.prio, ticket: ticket_counter,
                              st: ST_WAITING, arrival: rq.arrival};
          ticket_counter = ticket_counter + 16'd1;
          lv = 2'(rq.prio - PRIO_MIN);
          level_ring[lv][ring_tail[lv][TAG_W-1:0]] = rq.tag;
          ring_tail[lv] = ring_tail[lv] + 1'b1;
          used_tags = {used_tags, rq.tag};
          r = entry_report(RC_OK, rq.tag);
        end
      end
      REQ_CALL: begin
        r.result_code = RC_EMPTY;
        found = 1'b0;
        // stale slots are dropped on the way to the first waiting entry
        for (int l = 0; l < LVL_COUNT; l++) begin
          while (!found && ring_head[l] != ring_tail[l]) begin
            t = level_ring[l][ring_head[l][TAG_W-1:0]];
            ring_head[l] = ring_head[l] + 1'b1;
            if (tickets[t].used && tickets[t].st == ST_WAITING) begin
              tickets[t].st = ST_CALLED;
              r = entry_report(RC_OK, t);
              found = 1'b1;
            end
          end
        end
      end
      REQ_LOOKUP: begin
        if (!tickets[rq.tag].used) r.result_code = RC_NOT_FOUND;
        else r = entry_report(RC_OK, rq.tag);
      end
      REQ_CHANGE: begin
        if (rq.target > TGT_MAX) begin
          r.result_code = RC_BAD_STATE;
        end else if (!tickets[rq.tag].used) begin
          r.result_code = RC_NOT_FOUND;
        end else begin
          allowed = (tickets[rq.tag].st == ST_WAITING && rq.target[1:0] == ST_CALLED) ||
                    (tickets[rq.tag].st == ST_CALLED && rq.target[1:0] == ST_DONE) ||
                    (tickets[rq.tag].st == ST_WAITING && rq.target[1:0] == ST_CANCELLED);
          if (allowed) begin
            tickets[rq.tag].st = rq.target[1:0];
            r = entry_report(RC_OK, rq.tag);
          end else begin
            r = entry_report(RC_REFUSED, rq.tag);
          end
        end
      end
      REQ_CANCEL: begin
        if (!tickets[rq.tag].used) begin
          r.result_code = RC_NOT_FOUND;
        end else if (tickets[rq.tag].st != ST_WAITING) begin
          r = entry_report(RC_REFUSED, rq.tag);
        end else begin
          tickets[rq.tag].st = ST_CANCELLED;
          r = entry_report(RC_OK, rq.tag);
        end
      end
      default: r.result_code = RC_REFUSED;
    endcase
    return r;
  endfunction

  // mostly requests on tags already queued, with noise mixed in
  function automatic request_t next_random_request();
    request_t    rq;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (used_tags.size() != 0 && $urandom_range(0, 99) < 80)
      rq.tag = used_tags[$urandom_range(0, used_tags.size() - 1)];
    else
      rq.tag = 8'($urandom);
    rq.prio = ($urandom_range(0, 99) < 88) ? 3'($urandom_range(PRIO_MIN, PRIO_MAX))
                                            : 3'($urandom);
    rq.arrival = ($urandom_range(0, 99) < 95) ? 11'($urandom_range(0, 1439)) : 11'($urandom);
    rq.target = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, TGT_MAX)) : 3'($urandom);
    if (pick < 32) begin
      rq.req = REQ_INSERT;
      if ($urandom_range(0, 99) < 75) rq.tag = 8'($urandom);
    end else if (pick < 57) begin
      rq.req = REQ_CALL;
    end else if (pick < 72) begin
      rq.req = REQ_LOOKUP;
    end else if (pick < 87) begin
      rq.req = REQ_CHANGE;
    end else if (pick < 97) begin
      rq.req = REQ_CANCEL;
    end else begin
      rq.req = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    end
    return rq;
  endfunction

  function automatic plan_row_t req_row(input logic [2:0] req, input logic [7:0] tag,
                                        input logic [2:0] prio, input logic [10:0] arrival,
                                        input logic [2:0] target);
    plan_row_t row;
    row.rq    = '{req: req, tag: tag, prio: prio, arrival: arrival, target: target};
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic plan_row_t with_result(input plan_row_t row, input logic [2:0] code,
                                            input logic [7:0] tag, input logic [2:0] prio,
                                            input logic [15:0] ticket, input logic [1:0] st,
                                            input logic [10:0] arrival);
    row.typed             = 1'b1;
    row.want.result_code  = code;
    row.want.out_tag      = tag;
    row.want.out_priority = prio;
    row.want.out_ticket   = ticket;
    row.want.out_state    = st;
    row.want.out_arrival  = arrival;
    return row;
  endfunction

  function automatic void plan_add(input plan_row_t row);
    directed_plan = {directed_plan, row};
  endfunction

  function automatic string show_result(input res_t r);
    return $sformatf("code=%0d tag=%0d prio=%0d ticket=%0d state=%0d arrival=%0d",
                     r.result_code, r.out_tag, r.out_priority, r.out_ticket, r.out_state,
                     r.out_arrival);
  endfunction

  task automatic send_request(input request_t rq, input bit typed, input res_t typed_want);
    res_t want;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata  <= {4'b0, rq.target, rq.arrival, rq.prio, rq.tag, rq.req};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    want = queue_model_step(rq);
    if (typed) want = typed_want;
    pending_results = {pending_results, want};
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // result side: a counted hold-off overrides the random stalls
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[RES_W-1:0];
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result beat: %s", show_result(got));
      end else begin
        want = pending_results.pop_front();
        if (got.result_code !== want.result_code || got.out_tag !== want.out_tag ||
            got.out_priority !== want.out_priority || got.out_ticket !== want.out_ticket ||
            got.out_state !== want.out_state || got.out_arrival !== want.out_arrival) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result mismatch: expected %s, got %s", show_result(want),
                     show_result(got));
        end
      end
    end
  end

  initial begin
    #(12 * 1000000);
    $display("priority_ticket_queue_unit verification failed");
    $finish;
  end

  initial begin
    foreach (tickets[i]) tickets[i] = '{used: 1'b0, prio: '0, ticket: '0, st: '0, arrival: '0};
    foreach (ring_head[l]) begin
      ring_head[l] = '0;
      ring_tail[l] = '0;
    end
    ticket_counter = 16'd1;

    // empty store and rejected requests first, then a short life of a few tickets
    plan_add(with_result(req_row(REQ_CALL, 8'd0, 3'd0, 11'd0, 3'd0),
                         RC_EMPTY, '0, '0, '0, '0, '0));
    plan_add(with_result(req_row(REQ_LOOKUP, 8'd0, 3'd0, 11'd0, 3'd0),
                         RC_NOT_FOUND, '0, '0, '0, '0, '0));
    plan_add(with_result(req_row(REQ_CHANGE, 8'd255, 3'd7, 11'd2047, 3'd7),
                         RC_BAD_STATE, '0, '0, '0, '0, '0));
    plan_add(with_result(req_row(REQ_CHANGE, 8'd3, 3'd1, 11'd0, {1'b0, ST_CALLED}),
                         RC_NOT_FOUND, '0, '0, '0, '0, '0));
    plan_add(with_result(req_row(REQ_CANCEL, 8'd255, 3'd0, 11'd0, 3'd0),
                         RC_NOT_FOUND, '0, '0, '0, '0, '0));
    plan_add(with_result(req_row(REQ_INSERT, 8'd10, 3'd0, 11'd5, 3'd0),
                         RC_BAD_PRIO, '0, '0, '0, '0, '0));
    plan_add(with_result(req_row(REQ_INSERT, 8'd10, 3'd7, 11'd2047, 3'd7),
                         RC_BAD_PRIO, '0, '0, '0, '0, '0));
    plan_add(with_result(req_row(REQ_UNUSED_LO, 8'd1, 3'd1, 11'd1, 3'd1),
                         RC_REFUSED, '0, '0, '0, '0, '0));
    plan_add(with_result(req_row(REQ_UNUSED_HI, 8'd255, 3'd7, 11'd2047, 3'd7),
                         RC_REFUSED, '0, '0, '0, '0, '0));
    plan_add(with_result(req_row(REQ_INSERT, 8'd0, PRIO_MAX, 11'd0, 3'd0),
                         RC_OK, 8'd0, PRIO_MAX, 16'd1, ST_WAITING, 11'd0));
    plan_add(with_result(req_row(REQ_INSERT, 8'd255, PRIO_MIN, 11'd2047, 3'd0),
                         RC_OK, 8'd255, PRIO_MIN, 16'd2, ST_WAITING, 11'd2047));
    plan_add(with_result(req_row(REQ_INSERT, 8'd0, 3'd2, 11'd5, 3'd0),
                         RC_EXISTS, 8'd0, PRIO_MAX, 16'd1, ST_WAITING, 11'd0));
    plan_add(req_row(REQ_INSERT, 8'd128, PRIO_MAX, 11'd1439, 3'd0));
    plan_add(req_row(REQ_INSERT, 8'd77, 3'd2, 11'd700, 3'd0));
    plan_add(req_row(REQ_INSERT, 8'd78, 3'd3, 11'd701, 3'd0));
    plan_add(req_row(REQ_CANCEL, 8'd77, 3'd0, 11'd0, 3'd0));
    plan_add(req_row(REQ_CALL, 8'd0, 3'd0, 11'd0, 3'd0));
    plan_add(req_row(REQ_CALL, 8'd0, 3'd0, 11'd0, 3'd0));
    plan_add(req_row(REQ_CHANGE, 8'd78, 3'd0, 11'd0, {1'b0, ST_DONE}));
    plan_add(req_row(REQ_CHANGE, 8'd78, 3'd0, 11'd0, {1'b0, ST_DONE}));
    plan_add(req_row(REQ_CHANGE, 8'd128, 3'd0, 11'd0, {1'b0, ST_WAITING}));
    plan_add(req_row(REQ_CHANGE, 8'd0, 3'd0, 11'd0, {1'b0, ST_CALLED}));
    plan_add(req_row(REQ_CHANGE, 8'd128, 3'd0, 11'd0, {1'b0, ST_CANCELLED}));
    plan_add(req_row(REQ_CANCEL, 8'd128, 3'd0, 11'd0, 3'd0));
    plan_add(req_row(REQ_CALL, 8'd0, 3'd0, 11'd0, 3'd0));
    plan_add(req_row(REQ_LOOKUP, 8'd255, 3'd0, 11'd0, 3'd0));

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 33;
    recv_idle_pct = 65;
    foreach (directed_plan[i])
      send_request(directed_plan[i].rq, directed_plan[i].typed, directed_plan[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 65 : 0;
      recv_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 33 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // result side stops for a while, so the block backs up into the request side
        if (phase == 0 && n == 40) rx_hold = HOLD_CYCLES;
        send_request(next_random_request(), 1'b0, '0);
      end
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("priority_ticket_queue_unit verification clean");
    end else begin
      $display("priority_ticket_queue_unit verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/ptq_pkg.sv
rtl/priority_ticket_queue_unit.sv
tb/testbench.sv
